FILE: rtl/rc4_pkg.sv
// Shared types and constants for the RC4 cipher engine.
package rc4_pkg;

  localparam int PERM_DEPTH = 256;

  typedef logic [7:0] byte_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DJ,
    ST_DW1,
    ST_DW2,
    ST_KRD,
    ST_KJ,
    ST_KW1,
    ST_KW2
  } state_t;

  // Address source for the permutation read port
  typedef enum logic [2:0] {
    RD_NONE,
    RD_INEXT,
    RD_I,
    RD_JNXT,
    RD_T
  } rd_sel_t;

  typedef struct packed {
    logic    data_start;
    logic    key_write;
    logic    ks_start;
    rd_sel_t rd_sel;
    logic    j_step;
    logic    use_key;
    logic    wr_i;
    logic    wr_j;
    logic    out_load;
    logic    ks_step;
    logic    ks_done;
  } dp_cmd_t;

  typedef struct packed {
    logic i_last;
    logic out_busy;
  } dp_stat_t;

endpackage

FILE: rtl/rc4_ctrl.sv
// Sequencer for data items and the key schedule.
module rc4_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_mode,
  input  logic              in_last,
  output logic              in_ready,
  input  rc4_pkg::dp_stat_t stat,
  output rc4_pkg::dp_cmd_t  cmd
);

  rc4_pkg::state_t state_r;
  rc4_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rc4_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rc4_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_mode) begin
            state_nxt = rc4_pkg::ST_DJ;
          end else if (in_last) begin
            state_nxt = rc4_pkg::ST_KRD;
          end
        end
      end
      rc4_pkg::ST_DJ:  state_nxt = rc4_pkg::ST_DW1;
      rc4_pkg::ST_DW1: state_nxt = rc4_pkg::ST_DW2;
      rc4_pkg::ST_DW2: begin
        if (!stat.out_busy) begin
          state_nxt = rc4_pkg::ST_IDLE;
        end
      end
      rc4_pkg::ST_KRD: state_nxt = rc4_pkg::ST_KJ;
      rc4_pkg::ST_KJ:  state_nxt = rc4_pkg::ST_KW1;
      rc4_pkg::ST_KW1: state_nxt = rc4_pkg::ST_KW2;
      rc4_pkg::ST_KW2: begin
        state_nxt = stat.i_last ? rc4_pkg::ST_IDLE : rc4_pkg::ST_KRD;
      end
      default: state_nxt = rc4_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    cmd.rd_sel = rc4_pkg::RD_NONE;
    unique case (state_r)
      rc4_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_mode) begin
            cmd.data_start = 1'b1;
            cmd.rd_sel     = rc4_pkg::RD_INEXT;
          end else begin
            cmd.key_write = 1'b1;
            cmd.ks_start  = in_last;
          end
        end
      end
      rc4_pkg::ST_DJ: begin
        cmd.rd_sel = rc4_pkg::RD_JNXT;
        cmd.j_step = 1'b1;
      end
      rc4_pkg::ST_DW1: begin
        cmd.wr_i   = 1'b1;
        cmd.rd_sel = rc4_pkg::RD_T;
      end
      rc4_pkg::ST_DW2: begin
        cmd.wr_j     = !stat.out_busy;
        cmd.out_load = !stat.out_busy;
      end
      rc4_pkg::ST_KRD: begin
        cmd.rd_sel = rc4_pkg::RD_I;
      end
      rc4_pkg::ST_KJ: begin
        cmd.rd_sel  = rc4_pkg::RD_JNXT;
        cmd.j_step  = 1'b1;
        cmd.use_key = 1'b1;
      end
      rc4_pkg::ST_KW1: begin
        cmd.wr_i = 1'b1;
      end
      rc4_pkg::ST_KW2: begin
        cmd.wr_j    = 1'b1;
        cmd.ks_step = 1'b1;
        cmd.ks_done = stat.i_last;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

FILE: rtl/rc4_datapath.sv
// Permutation and key memories, indices, swap logic and output register.
module rc4_datapath #(
  parameter int KEY_MAX_BYTES = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  rc4_pkg::dp_cmd_t  cmd,
  output rc4_pkg::dp_stat_t stat,
  input  logic [7:0]        in_data_byte,
  input  logic              in_last,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [7:0]        out_out_byte,
  output logic              out_last_res
);

  localparam int KA_W  = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1;
  localparam int CNT_W = $clog2(KEY_MAX_BYTES + 1);

  rc4_pkg::byte_t perm_mem [rc4_pkg::PERM_DEPTH];
  rc4_pkg::byte_t key_mem  [KEY_MAX_BYTES];

  // Entry not written since the last identity load reads as its own index
  logic [rc4_pkg::PERM_DEPTH-1:0] pvalid_r;

  rc4_pkg::byte_t i_r, j_r, si_r, sj_r, byte_r;
  logic           last_r;
  rc4_pkg::byte_t pq_r, paddr_r, kq_r;
  logic           pv_r;
  logic [CNT_W-1:0] kcount_r;
  logic [KA_W-1:0]  kk_r;
  logic           out_valid_r, out_last_r;
  rc4_pkg::byte_t out_byte_r;

  rc4_pkg::byte_t perm_rd, j_nxt, rd_addr, wa, wd, ks;
  logic           rd_en, wr_en, key_full, key_we, kk_wrap;

  assign perm_rd  = pv_r ? pq_r : paddr_r;
  assign j_nxt    = j_r + perm_rd + (cmd.use_key ? kq_r : 8'd0);
  assign rd_en    = (cmd.rd_sel != rc4_pkg::RD_NONE);
  assign wr_en    = cmd.wr_i | cmd.wr_j;
  assign wa       = cmd.wr_i ? i_r : j_r;
  assign wd       = cmd.wr_i ? perm_rd : si_r;
  assign key_full = (kcount_r >= CNT_W'(KEY_MAX_BYTES));
  assign key_we   = cmd.key_write & ~key_full;
  assign kk_wrap  = ((CNT_W'(kk_r) + CNT_W'(1)) == kcount_r);

  // Keystream read went out before both swap writes landed: forward them
  assign ks = (paddr_r == j_r) ? si_r :
              (paddr_r == i_r) ? sj_r : perm_rd;

  always_comb begin
    unique case (cmd.rd_sel)
      rc4_pkg::RD_INEXT: rd_addr = i_r + 8'd1;
      rc4_pkg::RD_I:     rd_addr = i_r;
      rc4_pkg::RD_JNXT:  rd_addr = j_nxt;
      rc4_pkg::RD_T:     rd_addr = si_r + perm_rd;
      default:           rd_addr = i_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      perm_mem[wa] <= wd;
    end
    if (rd_en) begin
      pq_r    <= perm_mem[rd_addr];
      paddr_r <= rd_addr;
      pv_r    <= pvalid_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[kcount_r[KA_W-1:0]] <= in_data_byte;
    end
    if (cmd.rd_sel == rc4_pkg::RD_I) begin
      kq_r <= key_mem[kk_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvalid_r    <= '0;
      i_r         <= '0;
      j_r         <= '0;
      kcount_r    <= '0;
      kk_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.ks_start) begin
        pvalid_r <= '0;
      end else if (wr_en) begin
        pvalid_r[wa] <= 1'b1;
      end

      if (cmd.ks_start) begin
        i_r <= '0;
      end else if (cmd.data_start || cmd.ks_step) begin
        i_r <= i_r + 8'd1;
      end

      if (cmd.ks_start || cmd.ks_done) begin
        j_r <= '0;
      end else if (cmd.j_step) begin
        j_r <= j_nxt;
      end

      if (cmd.ks_start) begin
        kk_r <= '0;
      end else if (cmd.ks_step) begin
        kk_r <= kk_wrap ? '0 : kk_r + KA_W'(1);
      end

      if (cmd.ks_done) begin
        kcount_r <= '0;
      end else if (key_we) begin
        kcount_r <= kcount_r + CNT_W'(1);
      end

      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.data_start) begin
      byte_r <= in_data_byte;
      last_r <= in_last;
    end
    if (cmd.j_step) begin
      si_r <= perm_rd;
    end
    if (cmd.wr_i) begin
      sj_r <= perm_rd;
    end
    if (cmd.out_load) begin
      out_byte_r <= byte_r ^ ks;
      out_last_r <= last_r;
    end
  end

  assign stat = '{i_last: (i_r == 8'hFF), out_busy: (out_valid_r & ~out_ready)};

  assign out_valid    = out_valid_r;
  assign out_out_byte = out_byte_r;
  assign out_last_res = out_last_r;

endmodule

FILE: rtl/rc4_stream_cipher.sv
// RC4 engine top level: a data item steps through ST_DJ, ST_DW1 and ST_DW2 before the
// next accept, its result registered once the output is free; the single permutation
// read port sets this. A key item is taken in ST_IDLE; the last key item then runs the
// schedule (ST_KRD, ST_KJ, ST_KW1, ST_KW2 per permutation entry) with input held off.
// Synchronous active-low reset: identity permutation, indices and key count zero,
// no clearing pass (per-entry valid bits give the identity at once).
module rc4_stream_cipher #(
  parameter int KEY_MAX_BYTES = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_mode,
  input  logic [7:0] in_data_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_out_byte,
  output logic       out_last_res
);

  rc4_pkg::dp_cmd_t  cmd;
  rc4_pkg::dp_stat_t stat;

  rc4_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_last  (in_last),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rc4_datapath #(
    .KEY_MAX_BYTES (KEY_MAX_BYTES)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_data_byte (in_data_byte),
    .in_last      (in_last),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .out_out_byte (out_out_byte),
    .out_last_res (out_last_res)
  );

endmodule
